// ===== rtl/adjacency_degree_stats_core_defines.svh =====
// assertion macros shared by the adjacency degree statistics rtl
`ifndef ADJACENCY_DEGREE_STATS_CORE_DEFINES_SVH
`define ADJACENCY_DEGREE_STATS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold on every rising clock edge outside reset
`define ADS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define ADS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ADS_ASSERT(lbl, prop, msg)
`define ADS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/ads_pkg.sv =====
// types and constants of the adjacency degree statistics block
package ads_pkg;

	// default graph size
	localparam int NODES_DEF = 16;

	// fixed field widths
	localparam int NODE_W = 4;
	localparam int DEG_W  = 5;

	// operation codes carried in s_tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// input item data, from_node in the lowest bits
	typedef struct packed {
		logic [2:0]        pad;
		logic [NODE_W-1:0] query_node;
		logic              edge_present;
		logic [NODE_W-1:0] to_node;
		logic [NODE_W-1:0] from_node;
	} in_data_t;

	// result item data, out_degree in the lowest bits
	typedef struct packed {
		logic [6:0]        pad;
		logic [DEG_W-1:0]  count_out_one;
		logic [DEG_W-1:0]  count_one_in_one_out;
		logic [NODE_W-1:0] busiest_target;
		logic              node_symmetric;
		logic [DEG_W-1:0]  in_degree;
		logic [DEG_W-1:0]  out_degree;
	} res_data_t;

endpackage

// ===== rtl/adjacency_degree_stats_core.sv =====
// adjacency degree statistics core: matrix and degree memories with query scan
// edge write: accepted, then memory updated in the next cycle; no new item is taken meanwhile
// query: all rows scanned through S_SCAN and S_LAST, result registered in S_DONE; no new item until loaded
// query rate is set by the scan over the single read port of each memory
// new items are accepted while a finished result waits on the master side
// arst_n clears control, valid bits and output valid; matrix reads as empty
`include "adjacency_degree_stats_core_defines.svh"

module adjacency_degree_stats_core
	import ads_pkg::*;
#(
	parameter int NODES = NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// from_node[3:0], to_node[7:4], edge_present[8], query_node[12:9], zero pad
	input  logic [15:0] s_tdata,
	// operation[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_degree[4:0], in_degree[9:5], node_symmetric[10], busiest_target[14:11],
	// count_one_in_one_out[19:15], count_out_one[24:20], zero pad
	output logic [31:0] m_tdata
);

	localparam int IW = $clog2(NODES);
	localparam int DW = $clog2(NODES + 1);
	localparam int AW = NODES + DW;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_WR_UPD = 5'b00010,
		S_SCAN   = 5'b00100,
		S_LAST   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	in_data_t din;
	logic accept;

	// latched item fields
	logic              op_q;
	logic [NODE_W-1:0] from_q;
	logic [NODE_W-1:0] to_q;
	logic              present_q;
	logic [NODE_W-1:0] query_q;
	logic              wr_range_q;

	// memories: row bits with out-degree, and in-degree
	logic [AW-1:0] adj_mem [NODES];
	logic [DW-1:0] ind_mem [NODES];
	logic [NODES-1:0] adj_vld_q, ind_vld_q;
	logic [AW-1:0] adj_rd_s1;
	logic [DW-1:0] ind_rd_s1;
	logic adj_rv_s1, ind_rv_s1;
	logic [IW-1:0] adj_raddr, ind_raddr;

	// scan control
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;

	// accumulators
	logic [IW-1:0]    best_idx_q;
	logic [DW-1:0]    best_in_q;
	logic [DW-1:0]    both_q, outone_q;
	logic [DW-1:0]    od_sel_q, id_sel_q;
	logic [NODES-1:0] row_q, col_q;

	// output register
	logic      m_tvalid_q;
	res_data_t m_tdata_q;

	// read data with invalid entries seen as empty
	logic [AW-1:0]    adj_k;
	logic [DW-1:0]    in_k;
	logic [NODES-1:0] row_k;
	logic [DW-1:0]    od_k;

	// edge update
	logic [IW-1:0]    from_idx, to_idx, q_idx;
	logic             bit_old, upd;
	logic [NODES-1:0] row_new;
	logic [DW-1:0]    od_new, in_new;

	// result assembly
	logic      q_in_range, load_out;
	res_data_t res;

	assign din      = in_data_t'(s_tdata);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign from_idx = IW'(from_q);
	assign to_idx   = IW'(to_q);
	assign q_idx    = IW'(query_q);

	// read addresses: write item fields at accept (row 0 for a query), scan counter afterwards
	always_comb begin
		if (state_q == S_IDLE) begin
			adj_raddr = (s_tuser == OP_QUERY) ? '0 : IW'(din.from_node);
			ind_raddr = (s_tuser == OP_QUERY) ? '0 : IW'(din.to_node);
		end else begin
			adj_raddr = cnt_q;
			ind_raddr = cnt_q;
		end
	end

	assign adj_k = adj_rv_s1 ? adj_rd_s1 : '0;
	assign in_k  = ind_rv_s1 ? ind_rd_s1 : '0;
	assign row_k = adj_k[NODES-1:0];
	assign od_k  = adj_k[AW-1:NODES];

	// edge update values
	always_comb begin
		bit_old = row_k[to_idx];
		upd     = (state_q == S_WR_UPD) && wr_range_q && (present_q != bit_old);
		row_new = row_k;
		row_new[to_idx] = present_q;
		od_new  = present_q ? od_k + DW'(1) : od_k - DW'(1);
		in_new  = present_q ? in_k + DW'(1) : in_k - DW'(1);
	end

	// memory arrays with registered reads
	always_ff @(posedge clk) begin
		if (upd) begin
			adj_mem[from_idx] <= {od_new, row_new};
			ind_mem[to_idx]   <= in_new;
		end
		adj_rd_s1 <= adj_mem[adj_raddr];
		ind_rd_s1 <= ind_mem[ind_raddr];
	end

	// result fields
	always_comb begin
		q_in_range = (32'(query_q) < NODES);
		load_out   = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
		res = '0;
		res.out_degree           = q_in_range ? DEG_W'(od_sel_q) : '0;
		res.in_degree            = q_in_range ? DEG_W'(id_sel_q) : '0;
		res.node_symmetric       = q_in_range ? (row_q == col_q) : 1'b1;
		res.busiest_target       = NODE_W'(best_idx_q);
		res.count_one_in_one_out = DEG_W'(both_q);
		res.count_out_one        = DEG_W'(outone_q);
	end

	// control, valid bits and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			adj_vld_q  <= '0;
			ind_vld_q  <= '0;
			adj_rv_s1  <= 1'b0;
			ind_rv_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			adj_rv_s1 <= adj_vld_q[adj_raddr];
			ind_rv_s1 <= ind_vld_q[ind_raddr];
			vld_s1    <= (accept && s_tuser == OP_QUERY) || (state_q == S_SCAN);
			if (upd) begin
				adj_vld_q[from_idx] <= 1'b1;
				ind_vld_q[to_idx]   <= 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= IW'(1);
						state_q <= (s_tuser == OP_QUERY) ? S_SCAN : S_WR_UPD;
					end
				end
				S_WR_UPD: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (cnt_q == IW'(NODES - 1)) begin
						state_q <= S_LAST;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_LAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture, scan accumulation and result register
	always_ff @(posedge clk) begin
		idx_s1 <= (state_q == S_IDLE) ? '0 : cnt_q;
		if (accept) begin
			op_q       <= s_tuser;
			from_q     <= din.from_node;
			to_q       <= din.to_node;
			present_q  <= din.edge_present;
			query_q    <= din.query_node;
			wr_range_q <= (32'(din.from_node) < NODES) && (32'(din.to_node) < NODES);
			best_idx_q <= '0;
			best_in_q  <= '0;
			both_q     <= '0;
			outone_q   <= '0;
			od_sel_q   <= '0;
			id_sel_q   <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else if (vld_s1 && op_q == OP_QUERY) begin
			col_q[idx_s1] <= row_k[q_idx];
			if (idx_s1 == q_idx) begin
				row_q    <= row_k;
				od_sel_q <= od_k;
				id_sel_q <= in_k;
			end
			if (in_k > best_in_q) begin
				best_in_q  <= in_k;
				best_idx_q <= idx_s1;
			end
			if (od_k == DW'(1)) begin
				outone_q <= outone_q + DW'(1);
				if (in_k == DW'(1)) begin
					both_q <= both_q + DW'(1);
				end
			end
		end
		if (load_out) begin
			m_tdata_q <= res;
		end
	end

	// checks
	`ADS_ASSERT(a_scan_bound, (state_q == S_SCAN) |-> (32'(cnt_q) < NODES), "scan counter out of range")
	`ADS_ASSERT(a_write_no_result, (state_q == S_WR_UPD && !m_tvalid_q) |=> !m_tvalid_q, "write produced a result")
	`ADS_ASSERT(a_result_from_done, (!m_tvalid_q ##1 m_tvalid_q) |-> $past(state_q == S_DONE), "result loaded outside done")
	`ADS_ASSERT_NEVER(a_degree_overflow, upd && (32'(od_new) > NODES || 32'(in_new) > NODES), "degree counter out of range")

endmodule

// ===== bench/adjacency_degree_stats_core_tb.sv =====
// testbench for the adjacency degree statistics core: edge writes and queries checked by prediction
module adjacency_degree_stats_core_tb;
	import ads_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// one pending command for the sender
	typedef struct packed {
		logic     op;
		in_data_t data;
	} graph_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = OP_WRITE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	adjacency_degree_stats_core #(
		.NODES(NODES_DEF)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// graph mirror kept in step with accepted items
	logic [NODES_DEF-1:0] graph_rows   [NODES_DEF] = '{default: '0};
	logic [DEG_W-1:0]     node_out_deg [NODES_DEF] = '{default: '0};
	logic [DEG_W-1:0]     node_in_deg  [NODES_DEF] = '{default: '0};

	graph_cmd_t pending_cmds [$];
	res_data_t  expected_stats [$];

	int error_count = 0;
	int write_count = 0;
	int query_count = 0;
	int input_stall_cycles = 0;
	int peak_degree = 0;
	int peak_one_in_one_out = 0;

	// handshake flags passed from the sampling edge to the driving edge
	bit cmd_taken = 1'b0;
	bit stats_taken = 1'b0;

	int send_gap = 0;
	bit send_quiet = 1'b0;
	int recv_stall = 0;
	bit recv_quiet = 1'b0;
	int hold_cycles = 0;

	graph_cmd_t drv_cmd;
	logic       drv_next_valid;
	in_data_t   seen_cmd;
	res_data_t  seen_stats;
	res_data_t  want_stats;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("timeout with %0d commands and %0d results outstanding",
			pending_cmds.size(), expected_stats.size());
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 100)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// update the mirror for one edge write
	task automatic apply_edge_write(input logic [NODE_W-1:0] from_n,
		input logic [NODE_W-1:0] to_n, input logic present);
		if (present && !graph_rows[from_n][to_n]) begin
			graph_rows[from_n][to_n] = 1'b1;
			node_out_deg[from_n]++;
			node_in_deg[to_n]++;
		end else if (!present && graph_rows[from_n][to_n]) begin
			graph_rows[from_n][to_n] = 1'b0;
			node_out_deg[from_n]--;
			node_in_deg[to_n]--;
		end
		if (node_out_deg[from_n] > peak_degree)
			peak_degree = int'(node_out_deg[from_n]);
		if (node_in_deg[to_n] > peak_degree)
			peak_degree = int'(node_in_deg[to_n]);
	endtask

	// degree statistics the block should report for a query
	function automatic res_data_t predict_query_stats(input logic [NODE_W-1:0] node);
		res_data_t            r;
		logic [NODES_DEF-1:0] col;
		logic [NODE_W-1:0]    best;
		logic [DEG_W-1:0]     both;
		logic [DEG_W-1:0]     outone;
		r = '0;
		col = '0;
		best = '0;
		both = '0;
		outone = '0;
		for (int j = 0; j < NODES_DEF; j++)
			col[j] = graph_rows[j][node];
		for (int i = 0; i < NODES_DEF; i++) begin
			if (node_in_deg[i] > node_in_deg[best])
				best = i[NODE_W-1:0];
			if (node_out_deg[i] == 1) begin
				outone++;
				if (node_in_deg[i] == 1)
					both++;
			end
		end
		r.out_degree = node_out_deg[node];
		r.in_degree = node_in_deg[node];
		r.node_symmetric = (graph_rows[node] == col);
		r.busiest_target = best;
		r.count_one_in_one_out = both;
		r.count_out_one = outone;
		return r;
	endfunction

	// command builders, unused fields filled at random, pad zero
	task automatic push_write(input logic [NODE_W-1:0] from_n,
		input logic [NODE_W-1:0] to_n, input logic present);
		graph_cmd_t c;
		c.op = OP_WRITE;
		c.data.pad = '0;
		c.data.from_node = from_n;
		c.data.to_node = to_n;
		c.data.edge_present = present;
		c.data.query_node = NODE_W'($urandom_range(0, NODES_DEF - 1));
		pending_cmds.push_back(c);
	endtask

	task automatic push_query(input logic [NODE_W-1:0] node);
		graph_cmd_t c;
		c.op = OP_QUERY;
		c.data.pad = '0;
		c.data.from_node = NODE_W'($urandom_range(0, NODES_DEF - 1));
		c.data.to_node = NODE_W'($urandom_range(0, NODES_DEF - 1));
		c.data.edge_present = 1'($urandom_range(0, 1));
		c.data.query_node = node;
		pending_cmds.push_back(c);
	endtask

	// random mix with a bias toward setting or clearing edges
	task automatic push_random_mix(input int count, input int set_pct, input int query_pct);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < query_pct)
				push_query(NODE_W'($urandom_range(0, NODES_DEF - 1)));
			else
				push_write(NODE_W'($urandom_range(0, NODES_DEF - 1)),
					NODE_W'($urandom_range(0, NODES_DEF - 1)),
					$urandom_range(0, 99) < set_pct);
		end
	endtask

	// fill or clear a whole row or column, then ask about that node
	task automatic push_line_burst();
		logic [NODE_W-1:0] k;
		bit                by_row;
		logic              val;
		k = NODE_W'($urandom_range(0, NODES_DEF - 1));
		by_row = 1'($urandom_range(0, 1));
		val = ($urandom_range(0, 3) != 0);
		for (int j = 0; j < NODES_DEF; j++) begin
			if (by_row)
				push_write(k, j[NODE_W-1:0], val);
			else
				push_write(j[NODE_W-1:0], k, val);
		end
		push_query(k);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || s_tvalid || expected_stats.size() != 0);
	endtask

	// sender: one item at a time from the pending queue, random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			drv_next_valid = s_tvalid;
			if (s_tvalid && cmd_taken) begin
				drv_next_valid = 1'b0;
				cmd_taken = 1'b0;
			end
			if (!drv_next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_cmds.size() > 0) begin
					drv_cmd = pending_cmds.pop_front();
					s_tdata <= drv_cmd.data;
					s_tuser <= drv_cmd.op;
					drv_next_valid = 1'b1;
					if ($urandom_range(0, 47) == 0)
						send_quiet = ~send_quiet;
					send_gap = send_quiet ? 0 : $urandom_range(0, 14);
				end
			end
			s_tvalid <= drv_next_valid;
		end
	end

	// receiver: random stall per result, plus a long hold when asked
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (stats_taken) begin
				stats_taken = 1'b0;
				if ($urandom_range(0, 47) == 0)
					recv_quiet = ~recv_quiet;
				recv_stall = recv_quiet ? 0 : $urandom_range(0, 14);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				if (m_tvalid)
					recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// sampling: predict on accepted items, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !s_tready)
				input_stall_cycles++;
			if (s_tvalid && s_tready) begin
				cmd_taken = 1'b1;
				seen_cmd = in_data_t'(s_tdata);
				if (s_tuser == OP_QUERY) begin
					expected_stats.push_back(predict_query_stats(seen_cmd.query_node));
					query_count++;
				end else begin
					apply_edge_write(seen_cmd.from_node, seen_cmd.to_node,
						seen_cmd.edge_present);
					write_count++;
				end
			end
			if (m_tvalid && m_tready) begin
				stats_taken = 1'b1;
				seen_stats = res_data_t'(m_tdata);
				if (expected_stats.size() == 0) begin
					report_mismatch("result with no query outstanding");
				end else begin
					want_stats = expected_stats.pop_front();
					compare_field("out_degree", 8'(seen_stats.out_degree),
						8'(want_stats.out_degree));
					compare_field("in_degree", 8'(seen_stats.in_degree),
						8'(want_stats.in_degree));
					compare_field("node_symmetric", 8'(seen_stats.node_symmetric),
						8'(want_stats.node_symmetric));
					compare_field("busiest_target", 8'(seen_stats.busiest_target),
						8'(want_stats.busiest_target));
					compare_field("count_one_in_one_out",
						8'(seen_stats.count_one_in_one_out),
						8'(want_stats.count_one_in_one_out));
					compare_field("count_out_one", 8'(seen_stats.count_out_one),
						8'(want_stats.count_out_one));
					if (want_stats.count_one_in_one_out > peak_one_in_one_out)
						peak_one_in_one_out = int'(want_stats.count_one_in_one_out);
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// empty graph, extreme nodes, repeated and absent edges, self loop, ties
		push_query(4'd0);
		push_query(4'd15);
		push_write(4'd0, 4'd15, 1'b1);
		push_write(4'd0, 4'd15, 1'b1);
		push_query(4'd0);
		push_write(4'd15, 4'd0, 1'b1);
		push_query(4'd15);
		push_write(4'd5, 4'd5, 1'b1);
		push_query(4'd5);
		push_write(4'd3, 4'd3, 1'b0);
		push_write(4'd7, 4'd0, 1'b1);
		push_query(4'd7);
		push_write(4'd15, 4'd0, 1'b0);
		push_query(4'd0);
		push_write(4'd0, 4'd15, 1'b0);
		push_query(4'd15);
		wait_drained();

		// dense graph, then a long output hold while queries keep coming
		push_random_mix(500, 75, 25);
		for (int n = 0; n < 40; n++)
			push_query(NODE_W'($urandom_range(0, NODES_DEF - 1)));
		do
			@(posedge clk);
		while (pending_cmds.size() > 40);
		hold_cycles = 600;
		wait_drained();

		// full rows and columns mixed with random traffic
		for (int b = 0; b < 20; b++) begin
			push_line_burst();
			push_random_mix(10, 50, 30);
		end

		// sparse graph for degree-one counts, then balanced traffic
		push_random_mix(500, 25, 25);
		push_random_mix(350, 50, 20);
		wait_drained();
		repeat (4 * NODES_DEF) @(posedge clk);

		$display("ran %0d edge writes and %0d queries, peak degree %0d, peak one-in-one-out %0d",
			write_count, query_count, peak_degree, peak_one_in_one_out);
		$display("input held back for %0d cycles, %0d mismatches", input_stall_cycles,
			error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
